@@ src/aol_pkg.sv @@
// ============================================================================
// aol_pkg
// Shared types and codes for the array ordered list block.
// ============================================================================
package aol_pkg;

    localparam int FUNC_W = 3;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int STAT_W = 3;
    localparam int IDX_W  = 7;

    // Command word, one per accepted item.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } cmd_t;

    // Response word, exactly one per command.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] read_value;
        logic [IDX_W-1:0]  fill;
    } rsp_t;

    // Command codes.
    localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_READ_AT    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FIND       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS_AFTER  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 3'd4;
    localparam logic [FUNC_W-1:0] FN_REM_VALUE  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_REM_AT     = 3'd6;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd4;

    // Memory read address selection.
    localparam logic [1:0] RA_POS     = 2'd0;
    localparam logic [1:0] RA_PTR     = 2'd1;
    localparam logic [1:0] RA_PTR_DEC = 2'd2;
    localparam logic [1:0] RA_PTR_INC = 2'd3;

    // Memory write data selection.
    localparam logic WD_VALUE = 1'b0;
    localparam logic WD_READ  = 1'b1;

    // Working pointer operations.
    localparam logic [2:0] PO_HOLD = 3'd0;
    localparam logic [2:0] PO_ZERO = 3'd1;
    localparam logic [2:0] PO_CNT  = 3'd2;
    localparam logic [2:0] PO_POS  = 3'd3;
    localparam logic [2:0] PO_INC  = 3'd4;
    localparam logic [2:0] PO_DEC  = 3'd5;

    // Fill count operations, applied when the response is loaded.
    localparam logic [1:0] CO_NONE = 2'd0;
    localparam logic [1:0] CO_INC  = 2'd1;
    localparam logic [1:0] CO_DEC  = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [1:0]        rd_sel;
        logic              wr_en;
        logic              wr_sel;
        logic [2:0]        ptr_op;
        logic              cap_idx;
        logic              cap_rv;
        logic              fin;
        logic [1:0]        cnt_op;
        logic [STAT_W-1:0] stat;
        logic              found;
    } ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              pos_bad;
        logic              ptr_at_end;
        logic              ptr_last;
        logic              ptr_at_tgt;
        logic              match;
        logic              out_free;
        logic [IDX_W-1:0]  fill;
    } sts_t;

endpackage

@@ src/aol_ctrl.sv @@
// ============================================================================
// aol_ctrl
// Sequencer that steps each command through checks, scans and entry moves.
// ============================================================================
module aol_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  aol_pkg::sts_t  sts,
    output aol_pkg::ctl_t  ctl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_READ_CAP = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CMP = 4'd4;
    localparam logic [3:0] S_DOWN_CAP = 4'd5;
    localparam logic [3:0] S_DOWN_CHK = 4'd6;
    localparam logic [3:0] S_DOWN_WR  = 4'd7;
    localparam logic [3:0] S_UP_CHK   = 4'd8;
    localparam logic [3:0] S_UP_WR    = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0]                  state_reg, state_next;
    logic [aol_pkg::STAT_W-1:0]  stat_reg, stat_next;
    logic                        found_reg, found_next;
    logic [1:0]                  cop_reg, cop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= aol_pkg::ST_OK;
            found_reg <= 1'b0;
            cop_reg   <= aol_pkg::CO_NONE;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
            found_reg <= found_next;
            cop_reg   <= cop_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        ctl.stat   = stat_reg;
        ctl.found  = found_reg;
        ctl.cnt_op = cop_reg;
        state_next = state_reg;
        stat_next  = stat_reg;
        found_next = found_reg;
        cop_next   = cop_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.accept = 1'b1;
                    stat_next  = aol_pkg::ST_OK;
                    found_next = 1'b0;
                    cop_next   = aol_pkg::CO_NONE;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (sts.func)
                    aol_pkg::FN_APPEND:
                    begin
                        if (sts.full)
                        begin
                            stat_next  = aol_pkg::ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.ptr_op = aol_pkg::PO_CNT;
                            state_next = S_UP_CHK;
                        end
                    end
                    aol_pkg::FN_READ_AT:
                    begin
                        if (sts.pos_bad)
                        begin
                            stat_next  = aol_pkg::ST_BADPOS;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = aol_pkg::RA_POS;
                            state_next = S_READ_CAP;
                        end
                    end
                    aol_pkg::FN_FIND:
                    begin
                        ctl.ptr_op = aol_pkg::PO_ZERO;
                        state_next = S_SCAN_RD;
                    end
                    aol_pkg::FN_INS_AFTER, aol_pkg::FN_INS_BEFORE:
                    begin
                        if (sts.full)
                        begin
                            stat_next  = aol_pkg::ST_FULL;
                            state_next = S_FIN;
                        end
                        else if (sts.pos_bad)
                        begin
                            stat_next  = aol_pkg::ST_BADPOS;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.ptr_op = aol_pkg::PO_CNT;
                            state_next = S_UP_CHK;
                        end
                    end
                    aol_pkg::FN_REM_VALUE:
                    begin
                        if (sts.empty)
                        begin
                            stat_next  = aol_pkg::ST_EMPTY;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.ptr_op = aol_pkg::PO_ZERO;
                            state_next = S_SCAN_RD;
                        end
                    end
                    aol_pkg::FN_REM_AT:
                    begin
                        if (sts.empty)
                        begin
                            stat_next  = aol_pkg::ST_EMPTY;
                            state_next = S_FIN;
                        end
                        else if (sts.pos_bad)
                        begin
                            stat_next  = aol_pkg::ST_BADPOS;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = aol_pkg::RA_POS;
                            ctl.ptr_op = aol_pkg::PO_POS;
                            state_next = S_DOWN_CAP;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            S_READ_CAP:
            begin
                ctl.cap_rv = 1'b1;
                state_next = S_FIN;
            end

            S_SCAN_RD:
            begin
                if (sts.ptr_at_end)
                begin
                    // No match: the index reports the fill count.
                    ctl.cap_idx = 1'b1;
                    if (sts.func == aol_pkg::FN_REM_VALUE)
                    begin
                        stat_next = aol_pkg::ST_NOTFOUND;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = aol_pkg::RA_PTR;
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    ctl.cap_idx = 1'b1;
                    ctl.cap_rv  = 1'b1;
                    found_next  = 1'b1;
                    if (sts.func == aol_pkg::FN_FIND)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DOWN_CHK;
                    end
                end
                else
                begin
                    ctl.ptr_op = aol_pkg::PO_INC;
                    state_next = S_SCAN_RD;
                end
            end

            S_DOWN_CAP:
            begin
                ctl.cap_rv = 1'b1;
                state_next = S_DOWN_CHK;
            end

            S_DOWN_CHK:
            begin
                if (sts.ptr_last)
                begin
                    cop_next   = aol_pkg::CO_DEC;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = aol_pkg::RA_PTR_INC;
                    state_next = S_DOWN_WR;
                end
            end

            S_DOWN_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = aol_pkg::WD_READ;
                ctl.ptr_op = aol_pkg::PO_INC;
                state_next = S_DOWN_CHK;
            end

            S_UP_CHK:
            begin
                if (sts.ptr_at_tgt)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_sel = aol_pkg::WD_VALUE;
                    cop_next   = aol_pkg::CO_INC;
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = aol_pkg::RA_PTR_DEC;
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = aol_pkg::WD_READ;
                ctl.ptr_op = aol_pkg::PO_DEC;
                state_next = S_UP_CHK;
            end

            S_FIN:
            begin
                ctl.fin = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/aol_dpath.sv @@
// ============================================================================
// aol_dpath
// Entry memory, fill count, working pointer and response register.
// ============================================================================
module aol_dpath #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  aol_pkg::cmd_t  cmd,
    input  logic           rsp_stall,
    output logic           rsp_valid,
    output aol_pkg::rsp_t  rsp,
    input  aol_pkg::ctl_t  ctl,
    output aol_pkg::sts_t  sts
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IW     = aol_pkg::IDX_W;
    localparam int DW     = aol_pkg::DATA_W;

    logic [VALUE_WIDTH-1:0]       mem [DEPTH];
    logic [VALUE_WIDTH-1:0]       rdata_reg;

    logic [aol_pkg::FUNC_W-1:0]   func_reg;
    logic [aol_pkg::POS_W-1:0]    pos_reg;
    logic [VALUE_WIDTH-1:0]       val_reg;
    logic [CNT_W-1:0]             idx_reg;
    logic [VALUE_WIDTH-1:0]       rv_reg;

    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             ptr_reg, ptr_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    aol_pkg::rsp_t                rsp_reg, rsp_next;

    logic [IW-1:0]                cnt_x, ptr_x, pos_x, tgt_x;
    logic [ADDR_W-1:0]            rd_addr;
    logic [VALUE_WIDTH-1:0]       wdata;
    logic                         out_free;
    logic                         load;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign load     = ctl.fin && out_free;

    assign cnt_x = IW'(cnt_reg);
    assign ptr_x = IW'(ptr_reg);
    assign pos_x = IW'(pos_reg);

    // Position that receives the new value of an insert or append.
    always_comb
    begin
        case (func_reg)
            aol_pkg::FN_INS_AFTER:  tgt_x = pos_x + IW'(1);
            aol_pkg::FN_INS_BEFORE: tgt_x = pos_x;
            default:                tgt_x = cnt_x;
        endcase
    end

    always_comb
    begin
        sts.func       = func_reg;
        sts.full       = (cnt_reg == CNT_W'(DEPTH));
        sts.empty      = (cnt_reg == '0);
        sts.pos_bad    = (pos_x >= cnt_x);
        sts.ptr_at_end = (ptr_reg == cnt_reg);
        sts.ptr_last   = ((ptr_reg + CNT_W'(1)) == cnt_reg);
        sts.ptr_at_tgt = (ptr_x == tgt_x);
        sts.match      = (rdata_reg == val_reg);
        sts.out_free   = out_free;
        sts.fill       = cnt_x;
    end

    always_comb
    begin
        case (ctl.rd_sel)
            aol_pkg::RA_POS:     rd_addr = ADDR_W'(pos_reg);
            aol_pkg::RA_PTR:     rd_addr = ADDR_W'(ptr_reg);
            aol_pkg::RA_PTR_DEC: rd_addr = ADDR_W'(ptr_reg - CNT_W'(1));
            aol_pkg::RA_PTR_INC: rd_addr = ADDR_W'(ptr_reg + CNT_W'(1));
            default:             rd_addr = ADDR_W'(ptr_reg);
        endcase
    end

    assign wdata = (ctl.wr_sel == aol_pkg::WD_READ) ? rdata_reg : val_reg;

    // Single write port and single registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ADDR_W'(ptr_reg)] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        case (ctl.ptr_op)
            aol_pkg::PO_ZERO: ptr_next = '0;
            aol_pkg::PO_CNT:  ptr_next = cnt_reg;
            aol_pkg::PO_POS:  ptr_next = CNT_W'(pos_reg);
            aol_pkg::PO_INC:  ptr_next = ptr_reg + CNT_W'(1);
            aol_pkg::PO_DEC:  ptr_next = ptr_reg - CNT_W'(1);
            default:          ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        case (ctl.cnt_op)
            aol_pkg::CO_INC: cnt_next = cnt_reg + CNT_W'(1);
            aol_pkg::CO_DEC: cnt_next = cnt_reg - CNT_W'(1);
            default:         cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        rsp_next.status     = ctl.stat;
        rsp_next.found      = ctl.found;
        rsp_next.index      = IW'(idx_reg);
        rsp_next.read_value = DW'(rv_reg);
        rsp_next.fill       = IW'(cnt_next);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cnt_reg <= cnt_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctl.accept)
        begin
            func_reg <= cmd.func;
            pos_reg  <= cmd.position;
            val_reg  <= cmd.value[VALUE_WIDTH-1:0];
        end
        if (ctl.accept)
        begin
            idx_reg <= '0;
        end
        else if (ctl.cap_idx)
        begin
            idx_reg <= ptr_reg;
        end
        if (ctl.accept)
        begin
            rv_reg <= '0;
        end
        else if (ctl.cap_rv)
        begin
            rv_reg <= rdata_reg;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/array_ordered_list.sv @@
// ============================================================================
// array_ordered_list
// Ordered list of values held in an entry memory with a fill count.
// ============================================================================
//
//  Channel  Direction  Handshake             Word
//  -------  ---------  --------------------  ----------------------------------
//  cmd      in         cmd_valid, cmd_stall  func, position, value
//  rsp      out        rsp_valid, rsp_stall  status, found, index, read_value,
//                                            fill
//
//  One command is worked on at a time. A command that fails its checks goes
//  from decode straight to the final step, as does the unused code; read-at
//  reads its entry and captures it; find reads and compares each entry in
//  turn until one matches or the end is reached; insert and append move any
//  entries from the target onwards up one place, last first, and then write
//  the new value; remove-at moves the entries behind its position down one
//  place, and remove-value searches as find does and then moves likewise.
//  After the load the sequencer returns to idle before it can take the next
//  command. The entry memory has one registered read port: every move or
//  comparison needs one read, whose data arrives in the following cycle, and
//  a move then needs a write.
//  Reset clears the fill count and the controller at once; there is no
//  clearing pass, as entries beyond the fill count are never observed.
//  The next command is accepted while a response word still waits under
//  rsp_stall; that command finishes its work and then holds in its final
//  step until the response register is free.
//
// ============================================================================
module array_ordered_list #(
    parameter int DEPTH       = 64,   // 2 to 64 entries
    parameter int VALUE_WIDTH = 32    // 1 to 32 bits kept and compared
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  aol_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output aol_pkg::rsp_t  rsp
);

    // Command and status buses between the sequencer and the datapath.
    aol_pkg::ctl_t ctl;
    aol_pkg::sts_t sts;

    // The controller decodes each command, checks it against the fill count
    // and then walks the working pointer through the memory.
    aol_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // The datapath holds the entries, the fill count and the response
    // register, which parts the two channels.
    aol_dpath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .ctl       (ctl),
        .sts       (sts)
    );

    // Once a command has been taken, no further one is taken in the next
    // cycle: the sequencer is busy with it.
    a_one_at_a_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall
    ) else $error("command accepted while the previous one was in progress");

    // The entry memory is only written while a command is being worked on.
    a_write_when_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> cmd_stall
    ) else $error("entry memory written while idle");

    // A command that reports a failure leaves the fill count as it was.
    a_fail_keeps_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ctl.fin && sts.out_free && ctl.stat != aol_pkg::ST_OK)
            |=> (sts.fill == $past(sts.fill))
    ) else $error("fill count changed by a failed command");

    // A loaded response word always carries the fill count now held.
    a_rsp_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ctl.fin && sts.out_free) |=> (rsp_valid && rsp.fill == sts.fill)
    ) else $error("response fill differs from the fill count");

endmodule

@@ test/array_ordered_list_tb.sv @@
// ============================================================================
// array_ordered_list_tb
// Self-checking bench for the array ordered list block.
// ============================================================================
// Command words go in through a valid/stall channel that is driven in bursts.
// The response channel stalls on patterns of its own, and twice it holds off
// for a long stretch so that the block backs up. Every accepted command is
// run through a behavioural copy of the list kept inside the bench. Each
// response word is then compared field by field with the oldest outstanding
// prediction. A short table of hand-picked commands comes first. Random
// phases follow: mixed, growing, shrinking, filling to the top and draining.
// ============================================================================
module array_ordered_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH    = 64;
    localparam int VALUE_BITS    = 32;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_FIRST    = 30;
    localparam int HOLD_SECOND   = 900;

    // The only func code that the package leaves unnamed.
    localparam logic [aol_pkg::FUNC_W-1:0] FN_UNUSED = 3'd7;

    typedef enum int {PH_MIXED, PH_GROW, PH_SHRINK, PH_FILL, PH_DRAIN} phase_e;
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_e;

    // One row of the directed table. A row may be repeated, with the value
    // stepped by one on each repeat. Rows marked known carry their response.
    typedef struct packed {
        aol_pkg::cmd_t word;
        logic [6:0]    reps;
        logic          known;
        aol_pkg::rsp_t want;
    } plan_row_t;

    logic          clk;
    logic          rst_n     = 1'b0;
    logic          cmd_valid = 1'b0;
    aol_pkg::cmd_t cmd       = '0;
    logic          rsp_stall = 1'b0;
    logic          cmd_stall;
    logic          rsp_valid;
    aol_pkg::rsp_t rsp;

    // Behavioural copy of the list.
    logic [aol_pkg::DATA_W-1:0] list_image [LIST_DEPTH];
    int unsigned                list_len = 0;

    aol_pkg::rsp_t awaited_responses [$];
    plan_row_t     plan_q [$];
    int unsigned   mismatch_count = 0;
    int unsigned   rsp_seen       = 0;
    int unsigned   idle_cycles    = 0;
    int unsigned   burst_left     = 0;

    array_ordered_list #(
        .DEPTH       (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------------

    // Shifts the entries from position at upwards by one place and puts the
    // new value into the hole.
    function automatic void open_gap(input int unsigned at,
                                     input logic [aol_pkg::DATA_W-1:0] v);
        for (int unsigned i = list_len; i > at; i--)
        begin
            list_image[i] = list_image[i-1];
        end
        list_image[at] = v;
        list_len++;
    endfunction

    // Takes out the entry at a position and closes up the entries behind it.
    function automatic logic [aol_pkg::DATA_W-1:0] close_gap(input int unsigned at);
        logic [aol_pkg::DATA_W-1:0] taken;
        taken = list_image[at];
        for (int unsigned i = at; i + 1 < list_len; i++)
        begin
            list_image[i] = list_image[i+1];
        end
        list_len--;
        return taken;
    endfunction

    // Position of the first entry equal to v, or the length when none is.
    function automatic int unsigned locate(input logic [aol_pkg::DATA_W-1:0] v);
        int unsigned i;
        i = 0;
        while (i < list_len && list_image[i] != v)
        begin
            i++;
        end
        return i;
    endfunction

    // Applies one command word to the list copy and returns the response
    // word that the block must give for it.
    function automatic aol_pkg::rsp_t list_apply(input aol_pkg::cmd_t w);
        aol_pkg::rsp_t r;
        int unsigned   hit;
        r = '0;
        case (w.func)
            aol_pkg::FN_APPEND:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = aol_pkg::ST_FULL;
                else
                    open_gap(list_len, w.value);
            end
            aol_pkg::FN_READ_AT:
            begin
                if (w.position >= list_len)
                    r.status = aol_pkg::ST_BADPOS;
                else
                    r.read_value = list_image[w.position];
            end
            aol_pkg::FN_FIND:
            begin
                hit     = locate(w.value);
                r.index = aol_pkg::IDX_W'(hit);
                if (hit < list_len)
                begin
                    r.found      = 1'b1;
                    r.read_value = list_image[hit];
                end
            end
            aol_pkg::FN_INS_AFTER, aol_pkg::FN_INS_BEFORE:
            begin
                // Fullness takes precedence over a bad position.
                if (list_len >= LIST_DEPTH)
                    r.status = aol_pkg::ST_FULL;
                else if (w.position >= list_len)
                    r.status = aol_pkg::ST_BADPOS;
                else if (w.func == aol_pkg::FN_INS_AFTER)
                    open_gap(w.position + 1, w.value);
                else
                    open_gap(w.position, w.value);
            end
            aol_pkg::FN_REM_VALUE:
            begin
                if (list_len == 0)
                    r.status = aol_pkg::ST_EMPTY;
                else
                begin
                    hit     = locate(w.value);
                    r.index = aol_pkg::IDX_W'(hit);
                    if (hit < list_len)
                    begin
                        r.found      = 1'b1;
                        r.read_value = close_gap(hit);
                    end
                    else
                        r.status = aol_pkg::ST_NOTFOUND;
                end
            end
            aol_pkg::FN_REM_AT:
            begin
                if (list_len == 0)
                    r.status = aol_pkg::ST_EMPTY;
                else if (w.position >= list_len)
                    r.status = aol_pkg::ST_BADPOS;
                else
                    r.read_value = close_gap(w.position);
            end
            default:
            begin
                // The unused code leaves everything as it was.
            end
        endcase
        r.fill = aol_pkg::IDX_W'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void plan(input logic [aol_pkg::FUNC_W-1:0] f,
                                 input logic [aol_pkg::POS_W-1:0]  p,
                                 input logic [aol_pkg::DATA_W-1:0] v,
                                 input int                         reps,
                                 input logic                       known,
                                 input logic [aol_pkg::STAT_W-1:0] st,
                                 input logic [aol_pkg::DATA_W-1:0] rv,
                                 input logic [aol_pkg::IDX_W-1:0]  n);
        plan_row_t row;
        row                 = '0;
        row.word.func       = f;
        row.word.position   = p;
        row.word.value      = v;
        row.reps            = 7'(reps);
        row.known           = known;
        row.want.status     = st;
        row.want.read_value = rv;
        row.want.fill       = n;
        plan_q.push_back(row);
    endfunction

    // Values lean towards zero, all ones and a small pool, so that repeated
    // values and matches are common.
    function automatic logic [aol_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return aol_pkg::DATA_W'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    // Positions are mostly inside the list, with the first bad position, the
    // last entry and the whole field range mixed in.
    function automatic logic [aol_pkg::POS_W-1:0] pick_position();
        int unsigned r;
        int unsigned p;
        r = $urandom_range(0, 9);
        if (list_len == 0 || r == 0)
            p = $urandom_range(0, LIST_DEPTH - 1);
        else if (r == 1)
            p = (list_len >= LIST_DEPTH) ? LIST_DEPTH - 1 : list_len;
        else if (r == 2)
            p = list_len - 1;
        else
            p = $urandom_range(0, list_len - 1);
        return aol_pkg::POS_W'(p);
    endfunction

    function automatic aol_pkg::cmd_t gen_word(input phase_e ph);
        aol_pkg::cmd_t w;
        int unsigned   r;
        r          = $urandom_range(0, 99);
        w.value    = pick_value();
        w.position = pick_position();
        case (ph)
            PH_GROW:
                w.func = r < 40 ? aol_pkg::FN_APPEND     :
                         r < 55 ? aol_pkg::FN_INS_AFTER  :
                         r < 70 ? aol_pkg::FN_INS_BEFORE :
                         r < 78 ? aol_pkg::FN_READ_AT    :
                         r < 88 ? aol_pkg::FN_FIND       :
                         r < 94 ? aol_pkg::FN_REM_VALUE  : aol_pkg::FN_REM_AT;
            PH_SHRINK:
                w.func = r < 30 ? aol_pkg::FN_REM_VALUE :
                         r < 60 ? aol_pkg::FN_REM_AT    :
                         r < 70 ? aol_pkg::FN_READ_AT   :
                         r < 80 ? aol_pkg::FN_FIND      :
                         r < 88 ? aol_pkg::FN_APPEND    :
                         r < 94 ? aol_pkg::FN_INS_AFTER : aol_pkg::FN_INS_BEFORE;
            PH_FILL:
                w.func = r < 40 ? aol_pkg::FN_APPEND    :
                         r < 70 ? aol_pkg::FN_INS_AFTER : aol_pkg::FN_INS_BEFORE;
            PH_DRAIN:
                w.func = r < 50 ? aol_pkg::FN_REM_VALUE : aol_pkg::FN_REM_AT;
            default:
                w.func = r < 2  ? FN_UNUSED              :
                         r < 16 ? aol_pkg::FN_APPEND     :
                         r < 30 ? aol_pkg::FN_READ_AT    :
                         r < 44 ? aol_pkg::FN_FIND       :
                         r < 58 ? aol_pkg::FN_INS_AFTER  :
                         r < 72 ? aol_pkg::FN_INS_BEFORE :
                         r < 86 ? aol_pkg::FN_REM_VALUE  : aol_pkg::FN_REM_AT;
        endcase
        // Searches mostly look for a value that is really held.
        if ((w.func == aol_pkg::FN_FIND || w.func == aol_pkg::FN_REM_VALUE)
            && list_len > 0 && $urandom_range(0, 9) < 7)
            w.value = list_image[$urandom_range(0, list_len - 1)];
        return w;
    endfunction

    // Offers one command word, starting at a falling edge, and returns at the
    // falling edge after it was taken. Between bursts the valid line drops for
    // a random gap. The prediction is made at the accepting edge.
    task automatic send_word(input aol_pkg::cmd_t w, input logic known,
                             input aol_pkg::rsp_t want);
        int unsigned   gap;
        aol_pkg::rsp_t got;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 8);
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        got = list_apply(w);
        awaited_responses.push_back(known ? want : got);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    initial
    begin : cmd_side
        aol_pkg::cmd_t w;
        int unsigned   phase_left;
        phase_e        ph;

        list_image = '{default: '0};
        phase_left = 0;
        ph         = PH_MIXED;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Every failing command on an empty list, a find that misses, then the unused code.
        plan(aol_pkg::FN_READ_AT, 6'd0, 32'h0, 1, 1'b1, aol_pkg::ST_BADPOS, 32'h0, 7'd0);
        plan(aol_pkg::FN_REM_VALUE, 6'd0, 32'h0, 1, 1'b1, aol_pkg::ST_EMPTY, 32'h0, 7'd0);
        plan(aol_pkg::FN_REM_AT, 6'd0, 32'h0, 1, 1'b1, aol_pkg::ST_EMPTY, 32'h0, 7'd0);
        plan(aol_pkg::FN_INS_AFTER, 6'd0, 32'h1, 1, 1'b1, aol_pkg::ST_BADPOS, 32'h0, 7'd0);
        plan(aol_pkg::FN_INS_BEFORE, 6'd0, 32'h1, 1, 1'b1, aol_pkg::ST_BADPOS, 32'h0, 7'd0);
        plan(aol_pkg::FN_FIND, 6'd0, 32'h0, 1, 1'b1, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(FN_UNUSED, 6'd63, 32'hFFFFFFFF, 1, 1'b1, aol_pkg::ST_OK, 32'h0, 7'd0);
        // Extreme values, reading back and reading past the end.
        plan(aol_pkg::FN_APPEND, 6'd0, 32'hFFFFFFFF, 1, 1'b1, aol_pkg::ST_OK, 32'h0, 7'd1);
        plan(aol_pkg::FN_APPEND, 6'd63, 32'h0, 1, 1'b1, aol_pkg::ST_OK, 32'h0, 7'd2);
        plan(aol_pkg::FN_READ_AT, 6'd0, 32'h0, 1, 1'b1, aol_pkg::ST_OK, 32'hFFFFFFFF, 7'd2);
        plan(aol_pkg::FN_READ_AT, 6'd63, 32'h0, 1, 1'b1, aol_pkg::ST_BADPOS, 32'h0, 7'd2);
        // Inserts at both ends, a hit and a miss, and removals.
        plan(aol_pkg::FN_INS_BEFORE, 6'd0, 32'h12345678, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_INS_AFTER, 6'd2, 32'hA5A5A5A5, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_FIND, 6'd0, 32'h0, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_REM_VALUE, 6'd0, 32'hDEADBEEF, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_REM_VALUE, 6'd0, 32'hFFFFFFFF, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_REM_AT, 6'd3, 32'h0, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_REM_AT, 6'd0, 32'h0, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        // Fill to the top, then every growing command must report full.
        plan(aol_pkg::FN_APPEND, 6'd0, 32'h80000000, 62, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_APPEND, 6'd0, 32'h5A5A5A5A, 1, 1'b1, aol_pkg::ST_FULL, 32'h0, 7'd64);
        plan(aol_pkg::FN_INS_BEFORE, 6'd63, 32'h5A5A5A5A, 1, 1'b1, aol_pkg::ST_FULL,
             32'h0, 7'd64);
        plan(aol_pkg::FN_INS_AFTER, 6'd0, 32'h5A5A5A5A, 1, 1'b1, aol_pkg::ST_FULL,
             32'h0, 7'd64);
        // The last slot, a match there, a miss over a full list, and removals at both ends.
        plan(aol_pkg::FN_READ_AT, 6'd63, 32'h0, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_FIND, 6'd0, 32'h8000003D, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_FIND, 6'd0, 32'h7FFFFFFF, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_REM_AT, 6'd63, 32'h0, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);
        plan(aol_pkg::FN_REM_AT, 6'd0, 32'h0, 1, 1'b0, aol_pkg::ST_OK, 32'h0, 7'd0);

        foreach (plan_q[i])
        begin
            for (int k = 0; k < plan_q[i].reps; k++)
            begin
                w       = plan_q[i].word;
                w.value = w.value + aol_pkg::DATA_W'(k);
                send_word(w, plan_q[i].known, plan_q[i].want);
            end
        end

        // Random phases, each a run of commands biased one way.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                ph         = phase_e'($urandom_range(0, 4));
                phase_left = $urandom_range(20, 90);
            end
            phase_left--;
            send_word(gen_word(ph), 1'b0, '0);
        end
        cmd_valid <= 1'b0;

        // Drain, then watch a little longer for stray response words.
        while (awaited_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_responses.size() == 0)
            $display("[array_ordered_list] OK");
        else
            $display("[array_ordered_list] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response side: stall patterns, with two long hold-offs that let the
    // block fill up and push back on the command channel.
    // ------------------------------------------------------------------------
    initial
    begin : rsp_side
        int unsigned mode_left;
        int unsigned tick;
        int unsigned holds_done;
        rx_pattern_e pattern;

        mode_left  = 0;
        tick       = 0;
        holds_done = 0;
        pattern    = RX_FREE;
        forever
        begin
            @(negedge clk);
            if (holds_done < 2 && rsp_seen >= (holds_done == 0 ? HOLD_FIRST : HOLD_SECOND))
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    pattern   = rx_pattern_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                tick++;
                case (pattern)
                    RX_FREE:  rsp_stall <= 1'b0;
                    RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                    default:  rsp_stall <= (tick % 7 < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response checking, field by field against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : rsp_check
        aol_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen++;
            if (awaited_responses.size() == 0)
            begin
                $error("response word with nothing outstanding: %h", rsp);
                mismatch_count++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, rsp.found);
                    mismatch_count++;
                end
                if (rsp.index !== want.index)
                begin
                    $error("index: expected %0d, got %0d", want.index, rsp.index);
                    mismatch_count++;
                end
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
                    mismatch_count++;
                end
                if (rsp.fill !== want.fill)
                begin
                    $error("fill: expected %0d, got %0d", want.fill, rsp.fill);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("[array_ordered_list] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
src/aol_pkg.sv
src/aol_ctrl.sv
src/aol_dpath.sv
src/array_ordered_list.sv
test/array_ordered_list_tb.sv
